// ----- hdl/assert_macros.svh -----
// Assertion helpers used by sobel_edge_threshold_rgb.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising edge, off while reset is high.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/sobel_et_pkg.sv -----
// ----------------------------------------------------------------------------
// sobel_et_pkg
// Shared types, register codes and constants of the Sobel edge threshold block.
// ----------------------------------------------------------------------------
package sobel_et_pkg;

  // Default sizes of the line stores and counters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Configuration register widths
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int TH_W       = 9;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Output position widths
  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 10;

  // Pixel and arithmetic widths
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int MAG_W  = 21;
  localparam int LIM_W  = TH_W + 2;
  localparam int LIM2_W = 2 * LIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST    = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST   = 13'd768;
  localparam logic [TH_W-1:0] EDGE_THRESHOLD_RST = 9'd15;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [MAG_W-1:0]  mag_t;

  // One window column: index 0 is the top row, 2 the bottom row
  typedef pix_t [2:0] column_t;

  localparam chan_t CHAN_MAX = 8'hFF;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } in_item_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] out_row;
    logic [COL_OUT_W-1:0] out_col;
    chan_t                out_red;
    chan_t                out_green;
    chan_t                out_blue;
    logic                 is_edge;
    logic                 last_of_run;
  } out_item_t;

  // Status of one finished pixel, handed to the output buffer
  typedef struct packed {
    logic                 interior;
    logic                 border;
    logic                 edge_hit;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    pix_t                 pix;
  } res_pair_t;

endpackage

// ----- hdl/sobel_edge_threshold_rgb.sv -----
// The first result of a pixel is presented after the pixel has passed stage 1, stage 2
// and the output register. Throughput: one pixel per cycle while res_stall is low; a pixel
// with two results (an interior one and a border copy) holds the output register until both leave by its one port.
// Reset clears counters, window, pipeline valids and registers; the line stores
// are not cleared and hold data only once a full row has been written.
// ----------------------------------------------------------------------------
// sobel_edge_threshold_rgb
// Streaming 3x3 Sobel edge detector with threshold on RGB pixels in raster order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sobel_edge_threshold_rgb #(
  parameter int MAX_WIDTH  = sobel_et_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_et_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pix_valid,
  output logic                                   pix_stall,
  input  sobel_et_pkg::in_item_t                 pix,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output sobel_et_pkg::out_item_t                res,
  input  logic                                   cfg_we,
  input  logic [sobel_et_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sobel_et_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sobel_et_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Configuration registers
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [TH_W-1:0] edge_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_WIDTH_RST;
      frame_height   <= FRAME_HEIGHT_RST;
      edge_threshold <= EDGE_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[FH_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // Last column and row index of the clamped frame size
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  always_comb begin
    if (frame_width == '0) begin
      wm1 = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(frame_width - FW_W'(1));
    end
    if (frame_height == '0) begin
      hm1 = '0;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(frame_height - FH_W'(1));
    end
  end

  // Pipeline control
  logic pix_acc;
  logic s1_valid, s1_adv;
  logic s2_valid, s2_adv;
  logic ob_free;

  assign pix_acc   = pix_valid && !pix_stall;
  assign s2_adv    = s2_valid && ob_free;
  assign s1_adv    = s1_valid && (!s2_valid || s2_adv);
  assign pix_stall = s1_valid && !s1_adv;

  // Position counters, taken as zero when beyond the current size
  logic [RW-1:0] row_count, r_eff;
  logic [CW-1:0] col_count, c_eff;

  assign c_eff = (col_count > wm1) ? '0 : col_count;
  assign r_eff = (row_count > hm1) ? '0 : row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (pix_acc) begin
      if (c_eff == wm1) begin
        col_count <= '0;
        row_count <= (r_eff == hm1) ? '0 : r_eff + RW'(1);
      end else begin
        col_count <= c_eff + CW'(1);
        row_count <= r_eff;
      end
    end
  end

  // Stage 1: accepted pixel, line store read in flight
  pix_t          s1_pix;
  logic [RW-1:0] s1_row;
  logic [CW-1:0] s1_col;
  logic          s1_interior, s1_border;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_pix      <= {pix.red, pix.green, pix.blue};
      s1_row      <= r_eff;
      s1_col      <= c_eff;
      s1_interior <= (r_eff >= RW'(2)) && (c_eff >= CW'(2));
      s1_border   <= (r_eff == '0) || (r_eff == hm1) || (c_eff == '0) || (c_eff == wm1);
    end
  end

  // Line stores: upper half holds row y-2, lower half row y-1
  logic               ls_rd_en, ls_wr_en;
  logic [CW-1:0]      ls_rd_addr, ls_wr_addr;
  logic [2*PIX_W-1:0] ls_wr_data, ls_rd_data;

  assign ls_rd_en   = pix_acc;
  assign ls_rd_addr = c_eff;
  assign ls_wr_en   = s1_adv;
  assign ls_wr_addr = s1_col;
  assign ls_wr_data = {ls_rd_data[PIX_W-1:0], s1_pix};

  sobel_et_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (ls_rd_en),
    .rd_addr (ls_rd_addr),
    .wr_en   (ls_wr_en),
    .wr_addr (ls_wr_addr),
    .wr_data (ls_wr_data),
    .rd_data (ls_rd_data)
  );

  // Window: columns x-2 and x-1, current column from the line stores and the stage 1 pixel
  column_t col_new, win_old, win_mid;

  assign col_new[0] = ls_rd_data[2*PIX_W-1:PIX_W];
  assign col_new[1] = ls_rd_data[PIX_W-1:0];
  assign col_new[2] = s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_old <= '0;
      win_mid <= '0;
    end else if (s1_adv) begin
      win_old <= win_mid;
      win_mid <= col_new;
    end
  end

  mag_t [2:0] mag;

  sobel_et_grad u_grad (
    .col_old (win_old),
    .col_mid (win_mid),
    .col_new (col_new),
    .mag     (mag)
  );

  // Stage 2: magnitudes registered, threshold compare
  mag_t [2:0]    s2_mag;
  pix_t          s2_pix;
  logic [RW-1:0] s2_row;
  logic [CW-1:0] s2_col;
  logic          s2_interior, s2_border;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_mag      <= mag;
      s2_pix      <= s1_pix;
      s2_row      <= s1_row;
      s2_col      <= s1_col;
      s2_interior <= s1_interior;
      s2_border   <= s1_border;
    end
  end

  logic [LIM_W-1:0]  lim;
  logic [LIM2_W-1:0] lim2;
  res_pair_t         pair;

  always_comb begin
    lim  = {edge_threshold, 2'b00};
    lim2 = lim * lim;
    pair.interior = s2_interior;
    pair.border   = s2_border;
    pair.edge_hit = (LIM2_W'(s2_mag[0]) > lim2) || (LIM2_W'(s2_mag[1]) > lim2)
                 || (LIM2_W'(s2_mag[2]) > lim2);
    pair.row      = ROW_OUT_W'(s2_row);
    pair.col      = COL_OUT_W'(s2_col);
    pair.pix      = s2_pix;
  end

  sobel_et_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .load  (s2_adv),
    .pair  (pair),
    .free  (ob_free),
    .valid (res_valid),
    .stall (res_stall),
    .item  (res)
  );

  // Checks
  `ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !res_valid, "output valid right after reset")
  `ASSERT_AT(a_s1_hold, clk, rst, s1_valid && !s1_adv |=> s1_valid && s1_col == $past(s1_col), "stage 1 lost a held pixel")
  `ASSERT_AT(a_win_shift, clk, rst, s1_adv |=> win_old == $past(win_mid), "window did not shift")
  `ASSERT_AT(a_ls_bypass, clk, rst, ls_rd_en && ls_wr_en && ls_rd_addr == ls_wr_addr |=> ls_rd_data == $past(ls_wr_data), "line store bypass missed")

endmodule

// ----- hdl/sobel_et_line_store.sv -----
// ----------------------------------------------------------------------------
// sobel_et_line_store
// Two line stores held as one wide memory, registered read with write bypass.
// ----------------------------------------------------------------------------
module sobel_et_line_store #(
  parameter int DEPTH = sobel_et_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [2*sobel_et_pkg::PIX_W-1:0] wr_data,
  output logic [2*sobel_et_pkg::PIX_W-1:0] rd_data
);
  import sobel_et_pkg::*;

  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] mem_q;
  logic [2*PIX_W-1:0] byp_data;
  logic               byp;

  // Memory port: write and read in the same cycle, read returns old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // Forward a write that collides with the read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp ? byp_data : mem_q;

endmodule

// ----- hdl/sobel_et_grad.sv -----
// ----------------------------------------------------------------------------
// sobel_et_grad
// Sobel gradients per color channel and their squared magnitude.
// ----------------------------------------------------------------------------
module sobel_et_grad (
  input  sobel_et_pkg::column_t   col_old,
  input  sobel_et_pkg::column_t   col_mid,
  input  sobel_et_pkg::column_t   col_new,
  output sobel_et_pkg::mag_t [2:0] mag
);
  import sobel_et_pkg::*;

  // Weighted column sum a + 2b + c, ten bits wide
  function automatic logic [9:0] wsum(input chan_t a, input chan_t b, input chan_t c);
    wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  // Absolute value of an 11-bit gradient, fits in ten bits
  function automatic logic [9:0] absv(input logic signed [10:0] d);
    logic signed [10:0] nd;
    nd = -d;
    absv = d[10] ? nd[9:0] : d[9:0];
  endfunction

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic signed [10:0] dx, dy;
    logic [9:0]         ax, ay;
    logic [19:0]        sx, sy;

    always_comb begin
      dx = $signed({1'b0, wsum(col_new[0][ch*CHAN_W +: CHAN_W],
                               col_new[1][ch*CHAN_W +: CHAN_W],
                               col_new[2][ch*CHAN_W +: CHAN_W])})
         - $signed({1'b0, wsum(col_old[0][ch*CHAN_W +: CHAN_W],
                               col_old[1][ch*CHAN_W +: CHAN_W],
                               col_old[2][ch*CHAN_W +: CHAN_W])});
      dy = $signed({1'b0, wsum(col_old[2][ch*CHAN_W +: CHAN_W],
                               col_mid[2][ch*CHAN_W +: CHAN_W],
                               col_new[2][ch*CHAN_W +: CHAN_W])})
         - $signed({1'b0, wsum(col_old[0][ch*CHAN_W +: CHAN_W],
                               col_mid[0][ch*CHAN_W +: CHAN_W],
                               col_new[0][ch*CHAN_W +: CHAN_W])});
      ax = absv(dx);
      ay = absv(dy);
      sx = ax * ax;
      sy = ay * ay;
      mag[ch] = MAG_W'(sx) + MAG_W'(sy);
    end
  end

endmodule

// ----- hdl/sobel_et_out_buf.sv -----
// ----------------------------------------------------------------------------
// sobel_et_out_buf
// Two-slot output register: interior result first, then the border copy.
// ----------------------------------------------------------------------------
module sobel_et_out_buf (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  sobel_et_pkg::res_pair_t  pair,
  output logic                     free,
  output logic                     valid,
  input  logic                     stall,
  output sobel_et_pkg::out_item_t  item
);
  import sobel_et_pkg::*;

  out_item_t slot0, slot1;
  out_item_t int_item, bord_item;
  logic      has0, has1;

  // Build both candidate results
  always_comb begin
    int_item.out_row     = pair.row - ROW_OUT_W'(1);
    int_item.out_col     = pair.col - COL_OUT_W'(1);
    int_item.out_red     = pair.edge_hit ? CHAN_MAX : '0;
    int_item.out_green   = pair.edge_hit ? CHAN_MAX : '0;
    int_item.out_blue    = pair.edge_hit ? CHAN_MAX : '0;
    int_item.is_edge     = pair.edge_hit;
    int_item.last_of_run = !pair.border;

    bord_item.out_row     = pair.row;
    bord_item.out_col     = pair.col;
    bord_item.out_red     = pair.pix[3*CHAN_W-1:2*CHAN_W];
    bord_item.out_green   = pair.pix[2*CHAN_W-1:CHAN_W];
    bord_item.out_blue    = pair.pix[CHAN_W-1:0];
    bord_item.is_edge     = 1'b0;
    bord_item.last_of_run = 1'b1;
  end

  assign valid = has0 || has1;
  assign item  = has0 ? slot0 : slot1;
  // Free when empty or once the final pending result transfers this cycle
  assign free  = !valid || (!stall && !(has0 && has1));

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      has0 <= 1'b0;
      has1 <= 1'b0;
    end else if (load) begin
      has0 <= pair.interior || pair.border;
      has1 <= pair.interior && pair.border;
    end else if (valid && !stall) begin
      if (has0) begin
        has0 <= 1'b0;
      end else begin
        has1 <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= pair.interior ? int_item : bord_item;
      slot1 <= bord_item;
    end
  end

endmodule
